// ===== sv/tun_pkg.sv =====
// tun_pkg: widths, payload types and inter-module structs for the triangle
// unit-normal pipeline. No dependencies; used by every other file except tun_checker.
package tun_pkg;

  // field widths
  localparam int VW   = 32;   // vertex coordinate, Q16.16
  localparam int NW   = 16;   // normal component, Q1.14
  localparam int EW   = VW + 1;        // edge vector component
  localparam int PW   = 2 * EW;        // edge product
  localparam int MW   = PW;            // cross component magnitude
  localparam int HW   = MW / 2;        // half of a magnitude for squaring
  localparam int SQW  = 2 * MW;        // square of a magnitude, and sum of squares
  localparam int RW   = SQW + 1;       // divider partial remainder
  localparam int QW   = 31;            // quotient c^2 * 2^30 / S, at most 2^30
  localparam int NDIV = QW;            // one quotient bit per divider stage
  localparam int XW   = 32;            // square root working width
  localparam int NSQ  = 4;             // square root stages
  localparam int SQ_PER = 4;           // root bits resolved per stage

  typedef struct packed {
    logic signed [VW-1:0] v1_x;
    logic signed [VW-1:0] v1_y;
    logic signed [VW-1:0] v1_z;
    logic signed [VW-1:0] v2_x;
    logic signed [VW-1:0] v2_y;
    logic signed [VW-1:0] v2_z;
    logic signed [VW-1:0] v3_x;
    logic signed [VW-1:0] v3_y;
    logic signed [VW-1:0] v3_z;
  } in_item_t;

  typedef struct packed {
    logic signed [NW-1:0] normal_x;
    logic signed [NW-1:0] normal_y;
    logic signed [NW-1:0] normal_z;
    logic                 degenerate;
  } out_item_t;

  // divider request: squared components, their sum, signs, zero flag
  typedef struct packed {
    logic [2:0][SQW-1:0] sq;
    logic [SQW-1:0]      sum;
    logic [2:0]          neg;
    logic                degen;
  } div_req_t;

  // divider response: per-lane quotient plus passed-through flags
  typedef struct packed {
    logic [2:0][QW-1:0] quo;
    logic [2:0]         neg;
    logic               degen;
  } div_rsp_t;

endpackage

// ===== sv/tun_in_if.sv =====
// tun_in_if: valid/ready channel carrying one triangle request.
// Depends on tun_pkg for the payload type.
interface tun_in_if;
  logic             valid;
  logic             ready;
  tun_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/tun_out_if.sv =====
// tun_out_if: valid/ready channel carrying one unit-normal result.
// Depends on tun_pkg for the payload type.
interface tun_out_if;
  logic               valid;
  logic               ready;
  tun_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/tun_div.sv =====
// tun_div: three-lane pipelined restoring divider, one quotient bit per stage,
// forming floor(sq * 2^30 / sum). Depends on tun_pkg.
module tun_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              req_valid,
  input  tun_pkg::div_req_t req,
  output logic              rsp_valid,
  output tun_pkg::div_rsp_t rsp
);

  typedef struct packed {
    logic [2:0][tun_pkg::RW-1:0] rem;
    logic [2:0][tun_pkg::QW-1:0] quo;
    logic [tun_pkg::SQW-1:0]     sum;
    logic [2:0]                  neg;
    logic                        degen;
  } stg_t;

  stg_t stg_r [tun_pkg::NDIV];
  logic vld_r [tun_pkg::NDIV];

  genvar j;
  generate
    for (j = 0; j < tun_pkg::NDIV; j++) begin : g_stage
      stg_t src;
      stg_t stg_nxt;
      logic src_vld;

      // stage input: request for the first stage, previous stage otherwise
      if (j == 0) begin : g_first
        always_comb begin
          src.sum   = req.sum;
          src.neg   = req.neg;
          src.degen = req.degen;
          for (int l = 0; l < 3; l++) begin
            src.rem[l] = {1'b0, req.sq[l]};
            src.quo[l] = '0;
          end
        end
        assign src_vld = req_valid;
      end else begin : g_rest
        assign src     = stg_r[j-1];
        assign src_vld = vld_r[j-1];
      end

      // one trial subtraction per lane
      always_comb begin
        logic [tun_pkg::RW-1:0] sh;
        logic [tun_pkg::RW-1:0] dv;
        logic                   ge;
        stg_nxt = src;
        dv      = {1'b0, src.sum};
        for (int l = 0; l < 3; l++) begin
          sh = (j == 0) ? src.rem[l] : {src.rem[l][tun_pkg::RW-2:0], 1'b0};
          ge = (sh >= dv);
          stg_nxt.rem[l] = ge ? (sh - dv) : sh;
          stg_nxt.quo[l] = {src.quo[l][tun_pkg::QW-2:0], ge};
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[j] <= 1'b0;
        end else if (en) begin
          vld_r[j] <= src_vld;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          stg_r[j] <= stg_nxt;
        end
      end
    end
  endgenerate

  assign rsp_valid = vld_r[tun_pkg::NDIV-1];
  assign rsp.quo   = stg_r[tun_pkg::NDIV-1].quo;
  assign rsp.neg   = stg_r[tun_pkg::NDIV-1].neg;
  assign rsp.degen = stg_r[tun_pkg::NDIV-1].degen;

endmodule

// ===== sv/triangle_unit_normal.sv =====
// triangle_unit_normal: top level of the face-normal pipeline.
// Depends on tun_pkg, tun_in_if, tun_out_if and tun_div.
//
// Usage:
//   in_ch carries one triangle (three Q16.16 vertices) per request; out_ch
//   returns one result per request: the unit normal of (v3-v2) x (v1-v2) in
//   Q1.14, rounded to nearest, and a degenerate flag when the cross product
//   is zero (normal then all zero). Results leave in request order.
//   Throughput: one request per cycle, sustained while out_ch does not stall,
//   with no dependence between requests. A request passes from acceptance to
//   out_ch.valid through 6 front stages (edges, products, cross, partial
//   squares, squares, sum), 31 divider stages (one quotient bit each), 4 square
//   root stages and the output register.
//   Reset (rst_n low, synchronous) empties the pipeline; no result is shown
//   until a new request is taken.
//   When out_ch.ready is low with a result waiting, the whole pipeline holds
//   and in_ch.ready drops; bubbles still drain into an empty output slot.
module triangle_unit_normal (
  input  logic            clk,
  input  logic            rst_n,
  tun_in_if.sink          in_ch,
  tun_out_if.source       out_ch
);

  logic en;
  logic out_valid_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: edge vectors a = v3 - v2, b = v1 - v2
  logic                          v1_r;
  logic signed [tun_pkg::EW-1:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= {in_ch.data.v3_x[31], in_ch.data.v3_x} - {in_ch.data.v2_x[31], in_ch.data.v2_x};
      ay_r <= {in_ch.data.v3_y[31], in_ch.data.v3_y} - {in_ch.data.v2_y[31], in_ch.data.v2_y};
      az_r <= {in_ch.data.v3_z[31], in_ch.data.v3_z} - {in_ch.data.v2_z[31], in_ch.data.v2_z};
      bx_r <= {in_ch.data.v1_x[31], in_ch.data.v1_x} - {in_ch.data.v2_x[31], in_ch.data.v2_x};
      by_r <= {in_ch.data.v1_y[31], in_ch.data.v1_y} - {in_ch.data.v2_y[31], in_ch.data.v2_y};
      bz_r <= {in_ch.data.v1_z[31], in_ch.data.v1_z} - {in_ch.data.v2_z[31], in_ch.data.v2_z};
    end
  end

  // stage 2: six signed edge products
  logic                          v2_r;
  logic signed [tun_pkg::PW-1:0] p_r [3];
  logic signed [tun_pkg::PW-1:0] q_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= ay_r * bz_r;
      q_r[0] <= az_r * by_r;
      p_r[1] <= az_r * bx_r;
      q_r[1] <= ax_r * bz_r;
      p_r[2] <= ax_r * by_r;
      q_r[2] <= ay_r * bx_r;
    end
  end

  // stage 3: cross components as sign and magnitude
  logic                    v3_r;
  logic [2:0]              neg3_r;
  logic [tun_pkg::MW-1:0]  mag_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [tun_pkg::PW:0] diff;
    logic [tun_pkg::PW:0] absd;
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        diff = {p_r[l][tun_pkg::PW-1], p_r[l]} - {q_r[l][tun_pkg::PW-1], q_r[l]};
        absd = diff[tun_pkg::PW] ? (~diff + 1'b1) : diff;
        neg3_r[l] <= diff[tun_pkg::PW];
        mag_r[l]  <= absd[tun_pkg::MW-1:0];
      end
    end
  end

  // stage 4: partial products of each magnitude squared
  logic                     v4_r;
  logic [2:0]               neg4_r;
  logic [2*tun_pkg::HW-1:0] hh_r [3];
  logic [2*tun_pkg::HW-1:0] hl_r [3];
  logic [2*tun_pkg::HW-1:0] ll_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg4_r <= neg3_r;
      for (int l = 0; l < 3; l++) begin
        hh_r[l] <= mag_r[l][tun_pkg::MW-1:tun_pkg::HW] * mag_r[l][tun_pkg::MW-1:tun_pkg::HW];
        hl_r[l] <= mag_r[l][tun_pkg::MW-1:tun_pkg::HW] * mag_r[l][tun_pkg::HW-1:0];
        ll_r[l] <= mag_r[l][tun_pkg::HW-1:0] * mag_r[l][tun_pkg::HW-1:0];
      end
    end
  end

  // stage 5: assemble squares
  logic                    v5_r;
  logic [2:0]              neg5_r;
  logic [tun_pkg::SQW-1:0] sq_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg5_r <= neg4_r;
      for (int l = 0; l < 3; l++) begin
        sq_r[l] <= {hh_r[l], {(2*tun_pkg::HW){1'b0}}}
                 + {{(tun_pkg::HW-1){1'b0}}, hl_r[l], {(tun_pkg::HW+1){1'b0}}}
                 + {{(2*tun_pkg::HW){1'b0}}, ll_r[l]};
      end
    end
  end

  // stage 6: sum of squares and zero test, feeds the divider
  logic              v6_r;
  tun_pkg::div_req_t req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req_r.sq[0] <= sq_r[0];
      req_r.sq[1] <= sq_r[1];
      req_r.sq[2] <= sq_r[2];
      req_r.sum   <= sq_r[0] + sq_r[1] + sq_r[2];
      req_r.neg   <= neg5_r;
      req_r.degen <= ((sq_r[0] | sq_r[1] | sq_r[2]) == '0);
    end
  end

  // divider: floor(c^2 * 2^30 / |c|^2) per lane
  logic              div_valid;
  tun_pkg::div_rsp_t div_rsp;

  tun_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .req_valid (v6_r),
    .req       (req_r),
    .rsp_valid (div_valid),
    .rsp       (div_rsp)
  );

  // square root stages, SQ_PER root bits each
  typedef struct packed {
    logic [2:0][tun_pkg::XW-1:0] x;
    logic [2:0][tun_pkg::XW-1:0] res;
    logic [2:0]                  neg;
    logic                        degen;
  } sq_stg_t;

  sq_stg_t sqs_r [tun_pkg::NSQ];
  logic    sqv_r [tun_pkg::NSQ];

  genvar s;
  generate
    for (s = 0; s < tun_pkg::NSQ; s++) begin : g_sqrt
      sq_stg_t src;
      sq_stg_t sqs_nxt;
      logic    src_vld;

      if (s == 0) begin : g_first
        always_comb begin
          src.neg   = div_rsp.neg;
          src.degen = div_rsp.degen;
          for (int l = 0; l < 3; l++) begin
            src.x[l]   = {1'b0, div_rsp.quo[l]};
            src.res[l] = '0;
          end
        end
        assign src_vld = div_valid;
      end else begin : g_rest
        assign src     = sqs_r[s-1];
        assign src_vld = sqv_r[s-1];
      end

      // digit-by-digit restoring square root
      always_comb begin
        logic [tun_pkg::XW-1:0] bitv;
        logic [tun_pkg::XW-1:0] trial;
        sqs_nxt = src;
        for (int k = 0; k < tun_pkg::SQ_PER; k++) begin
          bitv = tun_pkg::XW'(1) << (tun_pkg::XW - 2 - 2 * (s * tun_pkg::SQ_PER + k));
          for (int l = 0; l < 3; l++) begin
            trial = sqs_nxt.res[l] + bitv;
            if (sqs_nxt.x[l] >= trial) begin
              sqs_nxt.x[l]   = sqs_nxt.x[l] - trial;
              sqs_nxt.res[l] = (sqs_nxt.res[l] >> 1) + bitv;
            end else begin
              sqs_nxt.res[l] = sqs_nxt.res[l] >> 1;
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sqv_r[s] <= 1'b0;
        end else if (en) begin
          sqv_r[s] <= src_vld;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          sqs_r[s] <= sqs_nxt;
        end
      end
    end
  endgenerate

  // output stage: halve with rounding, apply sign, mask degenerate
  tun_pkg::out_item_t out_r;
  logic [tun_pkg::NW-1:0] nrm_nxt [3];

  always_comb begin
    logic [tun_pkg::NW:0]   m17;
    logic [tun_pkg::NW-1:0] m;
    for (int l = 0; l < 3; l++) begin
      m17 = {1'b0, sqs_r[tun_pkg::NSQ-1].res[l][tun_pkg::NW-1:0]} + 1'b1;
      m   = m17[tun_pkg::NW:1];
      if (sqs_r[tun_pkg::NSQ-1].degen) begin
        nrm_nxt[l] = '0;
      end else if (sqs_r[tun_pkg::NSQ-1].neg[l] && (m != '0)) begin
        nrm_nxt[l] = ~m + 1'b1;
      end else begin
        nrm_nxt[l] = m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sqv_r[tun_pkg::NSQ-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.normal_x   <= nrm_nxt[0];
      out_r.normal_y   <= nrm_nxt[1];
      out_r.normal_z   <= nrm_nxt[2];
      out_r.degenerate <= sqs_r[tun_pkg::NSQ-1].degen;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

endmodule

// ===== sv/tun_checker.sv =====
// tun_checker: port-level assertions for triangle_unit_normal, plus the bind
// that attaches it. Depends on triangle_unit_normal's channel ports.
module tun_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic signed [15:0]     nx,
  input logic signed [15:0]     ny,
  input logic signed [15:0]     nz,
  input logic                   degen
);

  // stalled result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(nx) && $stable(ny) && $stable(nz)
      && $stable(degen))
    else $error("result changed while stalled");

  // an empty output slot never blocks new requests
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request refused with empty output");

  // degenerate result is the zero vector
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && degen |-> nx == 16'sd0 && ny == 16'sd0 && nz == 16'sd0)
    else $error("degenerate result not zero");

  // components stay within unit range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> nx >= -16'sd16384 && nx <= 16'sd16384 && ny >= -16'sd16384
      && ny <= 16'sd16384 && nz >= -16'sd16384 && nz <= 16'sd16384)
    else $error("normal component out of range");

endmodule

bind triangle_unit_normal tun_checker u_tun_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .nx        (out_ch.data.normal_x),
  .ny        (out_ch.data.normal_y),
  .nz        (out_ch.data.normal_z),
  .degen     (out_ch.data.degenerate)
);

// ===== verif/tb_triangle_unit_normal.sv =====
// tb_triangle_unit_normal: self-checking bench for the triangle unit-normal pipeline.
// Depends on tun_pkg, tun_in_if, tun_out_if and triangle_unit_normal (with tun_div).
module tb_triangle_unit_normal;

  localparam int ONE        = 32'h0001_0000;  // 1.0 in Q16.16
  localparam int UNIT       = 16384;          // 1.0 in Q1.14
  localparam int LATENCY    = 42;
  localparam int CYCLE_CAP  = 400000;
  localparam int N_RANDOM   = 130;            // per idle phase

  typedef struct {
    tun_pkg::in_item_t  tri_in;
    bit                 typed;     // expected value typed into the table
    tun_pkg::out_item_t want;
  } face_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tun_in_if  in_ch ();
  tun_out_if out_ch ();

  triangle_unit_normal dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #1 clk = ~clk;

  face_req_t           send_q[$];        // requests waiting to be offered
  tun_pkg::out_item_t  normal_q[$];      // expected normals, in request order
  face_req_t           cur_req;
  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  int                  recv_hold      = 0;
  int                  fail_cnt       = 0;
  int                  cycle_cnt      = 0;

  // Exact unit normal: sign-magnitude cross product, then the largest m with
  // (2m-1)^2 * |c|^2 <= c_i^2 * 2^30, found by binary search.
  function automatic tun_pkg::out_item_t unit_normal(tun_pkg::in_item_t t);
    logic signed [67:0] ax, ay, az, bx, by, bz;
    logic signed [67:0] c[3];
    logic [199:0]       mag[3];
    logic [199:0]       sumsq, rhs, lhs, odd;
    logic [15:0]        comp[3];
    int                 lo, hi, mid;
    tun_pkg::out_item_t r;
    ax = $signed(t.v3_x); ay = $signed(t.v3_y); az = $signed(t.v3_z);
    ax = ax - $signed(t.v2_x); ay = ay - $signed(t.v2_y); az = az - $signed(t.v2_z);
    bx = $signed(t.v1_x); by = $signed(t.v1_y); bz = $signed(t.v1_z);
    bx = bx - $signed(t.v2_x); by = by - $signed(t.v2_y); bz = bz - $signed(t.v2_z);
    c[0] = ay * bz - az * by;
    c[1] = az * bx - ax * bz;
    c[2] = ax * by - ay * bx;
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = 200'(c[i] < 0 ? -c[i] : c[i]);
      sumsq  = sumsq + mag[i] * mag[i];
    end
    r = '0;
    if (sumsq == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      rhs = (mag[i] * mag[i]) << 30;
      lo = 0;
      hi = UNIT;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        odd = 200'(2 * mid - 1);
        lhs = odd * odd * sumsq;
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      comp[i] = (c[i] < 0) ? 16'(-lo) : 16'(lo);
    end
    r.normal_x = comp[0];
    r.normal_y = comp[1];
    r.normal_z = comp[2];
    return r;
  endfunction

  function automatic tun_pkg::in_item_t make_tri(int x1, int y1, int z1,
                                                 int x2, int y2, int z2,
                                                 int x3, int y3, int z3);
    tun_pkg::in_item_t t;
    t.v1_x = x1; t.v1_y = y1; t.v1_z = z1;
    t.v2_x = x2; t.v2_y = y2; t.v2_z = z2;
    t.v3_x = x3; t.v3_y = y3; t.v3_z = z3;
    return t;
  endfunction

  function automatic tun_pkg::out_item_t make_normal(int nx, int ny, int nz, bit dg);
    tun_pkg::out_item_t o;
    o.normal_x = 16'(nx); o.normal_y = 16'(ny); o.normal_z = 16'(nz);
    o.degenerate = dg;
    return o;
  endfunction

  task automatic queue_tri(tun_pkg::in_item_t t, bit typed = 1'b0,
                           tun_pkg::out_item_t want = '0);
    face_req_t q;
    q.tri_in = t;
    q.typed  = typed;
    q.want   = want;
    send_q.push_back(q);
  endtask

  // Sender: records each accepted request, then offers the next one
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        normal_q.push_back(cur_req.typed ? cur_req.want : unit_normal(cur_req.tri_in));
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (send_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = send_q.pop_front();
          in_ch.data  <= cur_req.tri_in;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each delivered normal, stalls at random or for a long hold
  always @(posedge clk) begin
    tun_pkg::out_item_t exp_n;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (normal_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_ch.data);
          fail_cnt++;
        end else begin
          exp_n = normal_q.pop_front();
          if (out_ch.data.normal_x !== exp_n.normal_x) begin
            $display("%0t: normal_x expected %0d got %0d", $time,
                     exp_n.normal_x, out_ch.data.normal_x);
            fail_cnt++;
          end
          if (out_ch.data.normal_y !== exp_n.normal_y) begin
            $display("%0t: normal_y expected %0d got %0d", $time,
                     exp_n.normal_y, out_ch.data.normal_y);
            fail_cnt++;
          end
          if (out_ch.data.normal_z !== exp_n.normal_z) begin
            $display("%0t: normal_z expected %0d got %0d", $time,
                     exp_n.normal_z, out_ch.data.normal_z);
            fail_cnt++;
          end
          if (out_ch.data.degenerate !== exp_n.degenerate) begin
            $display("%0t: degenerate expected %0b got %0b", $time,
                     exp_n.degenerate, out_ch.data.degenerate);
            fail_cnt++;
          end
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("tb_triangle_unit_normal NOT OK");
      $finish;
    end
  end

  function automatic int rand_coord(int kind);
    case (kind)
      0:       return $urandom();
      1:       return $signed($urandom_range(2 * ONE * 64)) - ONE * 64;
      default: return ($signed($urandom_range(8)) - 4) * ONE;
    endcase
  endfunction

  // Random triangle: wide, small, collinear, repeated vertex or axis-aligned
  function automatic tun_pkg::in_item_t rand_tri();
    tun_pkg::in_item_t t;
    int kind, k, sel;
    kind = $urandom_range(2);
    t = make_tri(rand_coord(kind), rand_coord(kind), rand_coord(kind),
                 rand_coord(kind), rand_coord(kind), rand_coord(kind),
                 rand_coord(kind), rand_coord(kind), rand_coord(kind));
    sel = $urandom_range(9);
    if (sel == 0) begin
      // v1 on the line through v2 and v3
      k = $signed($urandom_range(6)) - 3;
      t = make_tri(rand_coord(1), rand_coord(1), rand_coord(1), 0, 0, 0, 0, 0, 0);
      t.v2_x = t.v1_x; t.v2_y = t.v1_y; t.v2_z = t.v1_z;
      t.v3_x = rand_coord(2); t.v3_y = rand_coord(2); t.v3_z = rand_coord(2);
      t.v1_x = t.v2_x + k * (t.v3_x - t.v2_x);
      t.v1_y = t.v2_y + k * (t.v3_y - t.v2_y);
      t.v1_z = t.v2_z + k * (t.v3_z - t.v2_z);
    end else if (sel == 1) begin
      t.v3_x = t.v2_x; t.v3_y = t.v2_y; t.v3_z = t.v2_z;
    end else if (sel == 2) begin
      // triangle in a z plane
      t.v2_z = t.v1_z; t.v3_z = t.v1_z;
    end
    return t;
  endfunction

  task automatic wait_drained();
    while (send_q.size() > 0 || in_ch.valid || normal_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    int idle_sets[4][2];
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    idle_sets = '{'{0, 0}, '{70, 0}, '{0, 70}, '{12, 12}};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: typed values where they are plain, predictor elsewhere
    queue_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, make_normal(0, 0, 0, 1));
    queue_tri(make_tri(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE), 1,
              make_normal(0, 0, 0, 1));
    queue_tri(make_tri(2 * ONE, 2 * ONE, 2 * ONE, 0, 0, 0, ONE, ONE, ONE), 1,
              make_normal(0, 0, 0, 1));
    queue_tri(make_tri(0, ONE, 0, 0, 0, 0, ONE, 0, 0), 1, make_normal(0, 0, UNIT, 0));
    queue_tri(make_tri(ONE, 0, 0, 0, 0, 0, 0, ONE, 0), 1, make_normal(0, 0, -UNIT, 0));
    queue_tri(make_tri(0, 0, ONE, 0, 0, 0, 0, ONE, 0), 1, make_normal(UNIT, 0, 0, 0));
    queue_tri(make_tri(ONE, 0, 0, 0, 0, 0, 0, 0, ONE), 1, make_normal(0, UNIT, 0, 0));
    queue_tri(make_tri(0, 0, 1, 0, 0, 0, 0, 1, 0), 1, make_normal(UNIT, 0, 0, 0));
    queue_tri(make_tri(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1,
              make_normal(0, 0, 0, 1));
    queue_tri(make_tri(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    queue_tri(make_tri(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    queue_tri(make_tri(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    // tiny y component next to a huge z one: must round to a plain zero
    queue_tri(make_tri(0, 32'h7FFF_FFFF, 1, 0, 0, 0, 32'h7FFF_FFFF, 0, 0));
    queue_tri(make_tri(0, 32'h7FFF_FFFF, -1, 0, 0, 0, 32'h7FFF_FFFF, 0, 0));
    // 45 degree and general small triangles
    queue_tri(make_tri(0, ONE, 0, 0, 0, 0, ONE, 0, ONE));
    queue_tri(make_tri(ONE, 2 * ONE, 3 * ONE, -ONE, 5, 7, 4 * ONE, -3 * ONE, ONE));
    queue_tri(make_tri(1, 0, 0, 0, 0, 0, 0, 1, 1));
    queue_tri(make_tri(-1, -1, -1, 0, 0, 0, 1, -1, 0));
    queue_tri(make_tri(32'h0000_0001, 32'hFFFF_FFFF, 32'h5555_5555,
                       32'hAAAA_AAAA, 32'h0000_0000, 32'h1234_5678,
                       32'hFEDC_BA98, 32'h7FFF_FFFF, 32'h8000_0001));
    wait_drained();

    // Random phases over the idle/stall settings
    foreach (idle_sets[p]) begin
      send_idle_pct  = idle_sets[p][0];
      recv_stall_pct = idle_sets[p][1];
      for (int i = 0; i < N_RANDOM; i++) queue_tri(rand_tri());
      if (p == 0) begin
        // long receiver hold while the sender keeps offering
        repeat (20) @(posedge clk);
        recv_hold = 200;
      end
      wait_drained();
    end

    recv_stall_pct = 0;
    repeat (LATENCY + 20) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb_triangle_unit_normal OK");
    end else begin
      $display("tb_triangle_unit_normal NOT OK");
    end
    $finish;
  end

endmodule
